// ----- sv/delta_list_timer_queue_assert.svh -----
// ----------------------------------------------------------------------------
// delta list timer queue assertion macros
// concurrent checks, compiled out when SYNTH is set
// ----------------------------------------------------------------------------
`ifndef DELTA_LIST_TIMER_QUEUE_ASSERT_SVH
`define DELTA_LIST_TIMER_QUEUE_ASSERT_SVH
`ifndef SYNTH
`define DLTQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define DLTQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DLTQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define DLTQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- sv/dltq_pkg.sv -----
// ----------------------------------------------------------------------------
// dltq_pkg
// shared codes and types of the delta list timer queue
// ----------------------------------------------------------------------------
package dltq_pkg;
    localparam logic [1:0] ACT_ARM    = 2'd0;
    localparam logic [1:0] ACT_DISARM = 2'd1;
    localparam logic [1:0] ACT_TICK   = 2'd2;

    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_EXPIRED = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [31:0] MAX_DELAY = 32'h7FFF_FFFF;
    localparam int unsigned MAX_EXPIRE = 16;

    // cell row operations
    localparam logic [2:0] OP_NOP = 3'd0;
    localparam logic [2:0] OP_INS = 3'd1;
    localparam logic [2:0] OP_REM = 3'd2;
    localparam logic [2:0] OP_POP = 3'd3;
    localparam logic [2:0] OP_SUB = 3'd4;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] val;
    } t_ctl;

    typedef struct packed {
        logic gt;
        logic past;
    } t_flags;
endpackage

// ----- sv/dltq_in_if.sv -----
// ----------------------------------------------------------------------------
// dltq_in_if
// request channel of the timer queue
// ----------------------------------------------------------------------------
interface dltq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [3:0]  timer_id;
    logic [31:0] amount;

    modport source (output valid, action, timer_id, amount, input ready);
    modport sink   (input valid, action, timer_id, amount, output ready);
endinterface

// ----- sv/dltq_out_if.sv -----
// ----------------------------------------------------------------------------
// dltq_out_if
// result channel of the timer queue
// ----------------------------------------------------------------------------
interface dltq_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [63:0] now_tick;
    logic        last;

    modport source (output valid, kind, slot, now_tick, last, input ready);
    modport sink   (input valid, kind, slot, now_tick, last, output ready);
endinterface

// ----- sv/dltq_cell.sv -----
// ----------------------------------------------------------------------------
// dltq_cell
// one queue position: slot id and ticks left until its expiry
// ----------------------------------------------------------------------------
module dltq_cell #(
    parameter int SLOT_W = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dltq_pkg::t_ctl       i_ctl,
    input  logic [SLOT_W-1:0]    i_id,
    input  dltq_pkg::t_flags     i_lft_flags,
    input  logic                 i_lft_valid,
    input  logic [SLOT_W-1:0]    i_lft_id,
    input  logic [31:0]          i_lft_rem,
    input  logic                 i_rgt_valid,
    input  logic [SLOT_W-1:0]    i_rgt_id,
    input  logic [31:0]          i_rgt_rem,
    output dltq_pkg::t_flags     o_flags,
    output logic                 o_valid,
    output logic [SLOT_W-1:0]    o_id,
    output logic [31:0]          o_rem
);
    import dltq_pkg::*;

    logic              r_valid, n_valid;
    logic [SLOT_W-1:0] r_id, n_id;
    logic [31:0]       r_rem, n_rem;

    always_comb begin
        o_flags.gt   = !r_valid || (r_rem > i_ctl.val);
        o_flags.past = i_lft_flags.past || (r_valid && r_id == i_id);
    end

    always_comb begin
        n_valid = r_valid;
        n_id    = r_id;
        n_rem   = r_rem;
        case (i_ctl.op)
            OP_INS: begin
                if (o_flags.gt) begin
                    if (i_lft_flags.gt) begin
                        n_valid = i_lft_valid;
                        n_id    = i_lft_id;
                        n_rem   = i_lft_rem;
                    end else begin
                        n_valid = 1'b1;
                        n_id    = i_id;
                        n_rem   = i_ctl.val;
                    end
                end
            end
            OP_REM: begin
                if (o_flags.past) begin
                    n_valid = i_rgt_valid;
                    n_id    = i_rgt_id;
                    n_rem   = i_rgt_rem;
                end
            end
            OP_POP: begin
                n_valid = i_rgt_valid;
                n_id    = i_rgt_id;
                n_rem   = i_rgt_rem - i_ctl.val;
            end
            OP_SUB: n_rem = r_rem - i_ctl.val;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_id  <= n_id;
        r_rem <= n_rem;
    end

    assign o_valid = r_valid;
    assign o_id    = r_id;
    assign o_rem   = r_rem;
endmodule

// ----- sv/delta_list_timer_queue.sv -----
// ----------------------------------------------------------------------------
// delta_list_timer_queue
// timer slots in a sorted row of cells with a 64-bit tick count
// ----------------------------------------------------------------------------
// Arm, disarm and unknown requests each give one result.
// The row holds armed slots sorted by expiry, each cell keeping the ticks
// left until its own expiry, so an insert or removal is one parallel shift.
// A tick request is accepted first, then the head cell pops one expired
// slot per cycle while the result register is free, up to MAX_EXPIRE of
// them, and a closing step takes the leftover time off the rest. A new
// request is taken only when the tick walk is done.
module delta_list_timer_queue #(
    parameter int TIMER_SLOTS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dltq_in_if.sink    i_in,
    dltq_out_if.source o_out
);
    import dltq_pkg::*;
    `include "delta_list_timer_queue_assert.svh"

    localparam int SLOT_W = (TIMER_SLOTS > 16) ? $clog2(TIMER_SLOTS) : 4;
    localparam int IDX_W  = $clog2(TIMER_SLOTS);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_TICK = 1'b1;

    logic             r_state, n_state;
    logic [31:0]      r_left, n_left;
    logic [4:0]       r_cnt, n_cnt;
    logic [63:0]      r_tick, n_tick;
    logic [TIMER_SLOTS-1:0] r_armed, n_armed;

    logic        r_ov, n_ov;
    logic [1:0]  r_kind, n_kind;
    logic [3:0]  r_slot, n_slot;
    logic [63:0] r_now, n_now;
    logic        r_last, n_last;

    t_ctl              w_ctl;
    logic [SLOT_W-1:0] w_id;
    logic              w_free, w_acc, w_inrange, w_exp, w_more;
    logic [31:0]       w_delay;

    t_flags            w_flg [TIMER_SLOTS+1];
    logic              w_cv  [TIMER_SLOTS+2];
    logic [SLOT_W-1:0] w_cid [TIMER_SLOTS+2];
    logic [31:0]       w_crem[TIMER_SLOTS+2];
    logic [TIMER_SLOTS-1:0] w_vvec;

    // index 0 is the empty left edge, TIMER_SLOTS+1 the empty right edge
    assign w_flg[0]                = '0;
    assign w_cv[0]                 = 1'b0;
    assign w_cid[0]                = '0;
    assign w_crem[0]               = '0;
    assign w_cv[TIMER_SLOTS+1]     = 1'b0;
    assign w_cid[TIMER_SLOTS+1]    = '0;
    assign w_crem[TIMER_SLOTS+1]   = '0;

    genvar g;
    generate
        for (g = 0; g < TIMER_SLOTS; g++) begin : g_cell
            dltq_cell #(.SLOT_W(SLOT_W)) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_ctl),
                .i_id        (w_id),
                .i_lft_flags (w_flg[g]),
                .i_lft_valid (w_cv[g]),
                .i_lft_id    (w_cid[g]),
                .i_lft_rem   (w_crem[g]),
                .i_rgt_valid (w_cv[g+2]),
                .i_rgt_id    (w_cid[g+2]),
                .i_rgt_rem   (w_crem[g+2]),
                .o_flags     (w_flg[g+1]),
                .o_valid     (w_cv[g+1]),
                .o_id        (w_cid[g+1]),
                .o_rem       (w_crem[g+1])
            );
            assign w_vvec[g] = w_cv[g+1];
        end
    endgenerate

    assign w_free    = !r_ov || o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE) && w_free;
    assign w_acc     = i_in.valid && i_in.ready;
    assign w_id      = SLOT_W'(i_in.timer_id);
    assign w_inrange = {28'd0, i_in.timer_id} < 32'(TIMER_SLOTS);
    assign w_delay   = (i_in.amount == 32'd0) ? 32'd1
                     : ((i_in.amount > MAX_DELAY) ? MAX_DELAY : i_in.amount);

    // head expires within what is left and under the expiry cap; w_more: its successor does too
    assign w_exp  = w_cv[1] && (w_crem[1] <= r_left) && (r_cnt < 5'(MAX_EXPIRE));
    assign w_more = w_cv[2] && (w_crem[2] <= r_left) && (r_cnt + 5'd1 < 5'(MAX_EXPIRE));

    always_comb begin
        n_state = r_state;
        n_left  = r_left;
        n_cnt   = r_cnt;
        n_tick  = r_tick;
        n_armed = r_armed;
        n_ov    = r_ov && !o_out.ready;
        n_kind  = r_kind;
        n_slot  = r_slot;
        n_now   = r_now;
        n_last  = r_last;
        w_ctl.op  = OP_NOP;
        w_ctl.val = w_delay;
        if (w_acc) begin
            n_ov   = 1'b1;
            n_kind = KIND_ACK;
            n_slot = i_in.timer_id;
            n_now  = r_tick;
            n_last = 1'b1;
            case (i_in.action)
                ACT_ARM: begin
                    if (!w_inrange || r_armed[IDX_W'(w_id)]) begin
                        n_kind = KIND_ERROR;
                    end else begin
                        w_ctl.op = OP_INS;
                        n_armed[IDX_W'(w_id)] = 1'b1;
                    end
                end
                ACT_DISARM: begin
                    if (w_inrange && r_armed[IDX_W'(w_id)]) begin
                        w_ctl.op = OP_REM;
                        n_armed[IDX_W'(w_id)] = 1'b0;
                    end
                end
                ACT_TICK: begin
                    n_ov    = r_ov && !o_out.ready;
                    n_state = ST_TICK;
                    n_left  = i_in.amount;
                    n_cnt   = '0;
                end
                default: ;
            endcase
        end else if (r_state == ST_TICK && w_free) begin
            if (w_exp) begin
                w_ctl.op  = OP_POP;
                w_ctl.val = w_crem[1];
                n_tick    = r_tick + 64'(w_crem[1]);
                n_left    = r_left - w_crem[1];
                n_cnt     = r_cnt + 5'd1;
                n_armed[IDX_W'(w_cid[1])] = 1'b0;
                n_ov   = 1'b1;
                n_kind = KIND_EXPIRED;
                n_slot = w_cid[1][3:0];
                n_now  = r_tick + 64'(w_crem[1]);
                n_last = !w_more;
            end else begin
                // leftover time comes off every waiting slot
                w_ctl.op  = OP_SUB;
                w_ctl.val = r_left;
                n_tick    = r_tick + 64'(r_left);
                n_state   = ST_IDLE;
                if (r_cnt == 5'd0) begin
                    n_ov   = 1'b1;
                    n_kind = KIND_ACK;
                    n_slot = 4'd0;
                    n_now  = r_tick + 64'(r_left);
                    n_last = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_tick  <= '0;
            r_armed <= '0;
            r_ov    <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_tick  <= n_tick;
            r_armed <= n_armed;
            r_ov    <= n_ov;
            r_cnt   <= n_cnt;
        end
        r_left <= n_left;
        r_kind <= n_kind;
        r_slot <= n_slot;
        r_now  <= n_now;
        r_last <= n_last;
    end

    assign o_out.valid    = r_ov;
    assign o_out.kind     = r_kind;
    assign o_out.slot     = r_slot;
    assign o_out.now_tick = r_now;
    assign o_out.last     = r_last;

    `DLTQ_ASSERT_IMPL(a_no_req_in_tick, i_clk, i_rst_n, r_state == ST_TICK, !i_in.ready, "request taken during tick walk")
    `DLTQ_ASSERT_IMPL(a_armed_count, i_clk, i_rst_n, 1'b1, $countones(r_armed) == $countones(w_vvec), "armed flags and queue cells disagree")
    `DLTQ_ASSERT_IMPL(a_packed_row, i_clk, i_rst_n, !w_cv[1], w_vvec == '0, "queue has a hole at the head")
    `DLTQ_ASSERT_NEXT(a_tick_starts, i_clk, i_rst_n, w_acc && i_in.action == ACT_TICK, r_state == ST_TICK, "tick request did not start a walk")
endmodule
